@@ design/mcas_pkg.sv @@
// Shared types and constants for the assignment solver.
`default_nettype none
package mcas_pkg;
  localparam int CostW = 16;
  localparam int DualW = 40;
  localparam int OutW = 24;
  localparam int SlackW = 40;
  localparam logic [SlackW-1:0] SlackMax = {1'b0, {(SlackW-1){1'b1}}};

  typedef struct packed {
    logic [3:0]  index;
    logic [3:0]  assigned_col;
    logic [3:0]  assigned_row;
    logic [23:0] row_dual;
    logic [23:0] col_dual;
    logic [23:0] total_cost;
    logic        last;
  } result_t;

  function automatic logic [OutW-1:0] sat24(input logic signed [DualW-1:0] x);
    if (x > 40'sd8388607) return 24'h7FFFFF;
    else if (x < -40'sd8388608) return 24'h800000;
    else return x[OutW-1:0];
  endfunction
endpackage
`default_nettype wire

@@ design/mcas_cost_mem.sv @@
// Cost matrix memory: one write port, one registered read port.
`default_nettype none
module mcas_cost_mem
  import mcas_pkg::*;
#(
  parameter int AW = 8
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic signed [CostW-1:0] wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic signed [CostW-1:0]      rdata
);
  logic signed [CostW-1:0] mem [2**AW];

  // write and read the store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/min_cost_assignment_solver.sv @@
// Minimum-cost assignment solver: Hungarian method, depth-first augmentation.
// Load: one cost word per cycle; the word with tlast starts the solve.
// Solve: sequential, each tested edge reads the cost memory (states EDGE_RD, EDGE_LT,
//   EDGE_WT; a skipped visited column takes no read), column minimum pass n*n reads,
//   dual update over n rows and columns per round; data-dependent.
// Output: n words after the solve, one per cycle while m_tready holds.
// Reset (rst, synchronous): dimension 16, idle, no cost memory clear.
`default_nettype none
module min_cost_assignment_solver
  import mcas_pkg::*;
#(
  parameter int MAX_DIM = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // row[3:0], col[7:4], cost_value[23:8]
  input  wire logic        s_tlast,   // last_entry
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,   // index, assigned_col, assigned_row, row_dual,
                                      // col_dual, total_cost, 4 zero bits
  output logic             m_tlast    // last
);
  localparam int IW = $clog2(MAX_DIM);
  localparam int NW = IW + 1;
  localparam int AW = 2 * IW;
  localparam int LIM = (MAX_DIM > 16) ? 16 : MAX_DIM;

  typedef enum logic [3:0] {
    S_LOAD, S_MIN_RD, S_MIN_WT, S_ROW, S_ROUND, S_EDGE_RD, S_EDGE_LT, S_EDGE_WT,
    S_AUG, S_THETA, S_UPD, S_TOTAL, S_OUT
  } state_t;

  state_t state;
  logic [4:0] dimension;
  logic [NW-1:0] n, i, j, r, rnd;
  logic [IW:0] k;
  logic signed [DualW-1:0] row_duals [MAX_DIM];
  logic signed [DualW-1:0] col_duals [MAX_DIM];
  logic [SlackW-1:0] slack [MAX_DIM];
  logic [MAX_DIM-1:0] owned;
  logic [IW-1:0] col_owner [MAX_DIM];
  logic [IW-1:0] row_partner [MAX_DIM];
  logic [MAX_DIM-1:0] vrows, vcols;
  logic [IW-1:0] st_row [MAX_DIM+1];
  logic [NW-1:0] st_next [MAX_DIM+1];
  logic [IW-1:0] st_via [MAX_DIM+1];
  logic [NW:0] depth;
  logic signed [CostW-1:0] colmin;
  logic [SlackW-1:0] theta;
  logic signed [DualW-1:0] total;
  logic [AW-1:0] raddr;
  logic signed [CostW-1:0] rdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [3:0] in_row, in_col;
  logic [NW-1:0] nsel;
  logic signed [DualW-1:0] gap2;
  logic [SlackW-1:0] gap;
  logic [IW-1:0] cur_row, ji;
  result_t res;

  assign in_row = s_tdata[3:0];
  assign in_col = s_tdata[7:4];
  assign s_tready = (state == S_LOAD);
  assign we = s_tvalid && s_tready && ({28'd0, in_row} < 32'(MAX_DIM))
              && ({28'd0, in_col} < 32'(MAX_DIM));
  assign waddr = {IW'(in_row), IW'(in_col)};
  assign ji = j[IW-1:0];
  assign cur_row = st_row[depth[IW:0]];

  // clamp dimension
  always_comb begin
    if (dimension == 5'd0) nsel = NW'(1);
    else if ({1'b0, dimension} > 6'(LIM)) nsel = NW'(LIM);
    else nsel = NW'(dimension);
  end

  // edge slack: magnitude of the half-unit difference, halved
  always_comb begin
    gap2 = 2 * DualW'(rdata) - row_duals[cur_row] - col_duals[ji];
    if (gap2 < 0) gap2 = -gap2;
    gap = SlackW'(gap2 >>> 1);
  end

  mcas_cost_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(s_tdata[23:8]),
    .raddr(raddr), .rdata(rdata)
  );

  // output word
  always_comb begin
    res.index = 4'(i);
    res.assigned_col = (owned[row_partner[i[IW-1:0]]]
      && col_owner[row_partner[i[IW-1:0]]] == i[IW-1:0]) ? 4'(row_partner[i[IW-1:0]]) : 4'd0;
    res.assigned_row = owned[i[IW-1:0]] ? 4'(col_owner[i[IW-1:0]]) : 4'd0;
    res.row_dual = sat24(row_duals[i[IW-1:0]]);
    res.col_dual = sat24(col_duals[i[IW-1:0]]);
    res.total_cost = sat24(total >>> 1);
    res.last = (i == n - NW'(1));
  end
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {4'd0, res.total_cost, res.col_dual, res.row_dual,
                    res.assigned_row, res.assigned_col, res.index};
  assign m_tlast = res.last;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      dimension <= 5'd16;
      owned <= '0;
    end else begin
      if (cfg_we) dimension <= cfg_wdata;
      case (state)
        S_LOAD: if (s_tvalid && s_tlast) begin
          n <= nsel;
          owned <= '0;
          for (int q = 0; q < MAX_DIM; q++) begin
            row_duals[q] <= '0;
            col_duals[q] <= '0;
            row_partner[q] <= '0;
          end
          i <= '0; j <= '0;
          raddr <= '0;
          state <= S_MIN_RD;
        end
        S_MIN_RD: state <= S_MIN_WT;
        S_MIN_WT: begin
          // advance column minimum scan, rows within a column
          if (i == '0 || rdata < colmin) colmin <= rdata;
          if (i == n - NW'(1)) begin
            col_duals[ji] <= 2 * DualW'((i == '0 || rdata < colmin) ? rdata : colmin);
            i <= '0;
            if (j == n - NW'(1)) begin
              r <= '0;
              state <= S_ROW;
            end else begin
              j <= j + NW'(1);
              raddr <= {IW'(0), IW'(j + NW'(1))};
              state <= S_MIN_RD;
            end
          end else begin
            i <= i + NW'(1);
            raddr <= {IW'(i + NW'(1)), ji};
            state <= S_MIN_RD;
          end
        end
        S_ROW: begin
          if (r == n) begin
            total <= '0; i <= '0;
            state <= S_TOTAL;
          end else begin
            for (int q = 0; q < MAX_DIM; q++) slack[q] <= SlackMax;
            rnd <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          vrows <= MAX_DIM'(1) << r[IW-1:0];
          vcols <= '0;
          depth <= '0;
          st_row[0] <= r[IW-1:0];
          j <= '0;
          state <= S_EDGE_RD;
        end
        S_EDGE_RD: begin
          // skip visited columns, end frame when exhausted
          if (j >= n) begin
            if (depth == '0) begin
              theta <= SlackMax; j <= '0;
              state <= S_THETA;
            end else begin
              depth <= depth - 1'b1;
              j <= st_next[depth[IW:0] - 1'b1];
            end
          end else if (vcols[ji]) begin
            j <= j + NW'(1);
          end else begin
            raddr <= {cur_row, ji};
            state <= S_EDGE_LT;
          end
        end
        // wait for the cost read
        S_EDGE_LT: state <= S_EDGE_WT;
        S_EDGE_WT: begin
          if (gap != '0) begin
            if (gap < slack[ji]) slack[ji] <= gap;
            j <= j + NW'(1);
            state <= S_EDGE_RD;
          end else begin
            vcols[ji] <= 1'b1;
            st_next[depth[IW:0]] <= j + NW'(1);
            st_via[depth[IW:0]] <= ji;
            if (!owned[ji]) begin
              k <= depth[IW:0];
              state <= S_AUG;
            end else begin
              depth <= depth + 1'b1;
              st_row[depth[IW:0] + 1'b1] <= col_owner[ji];
              vrows[col_owner[ji]] <= 1'b1;
              j <= '0;
              state <= S_EDGE_RD;
            end
          end
        end
        S_AUG: begin
          // flip the path, one frame a cycle
          owned[st_via[k]] <= 1'b1;
          col_owner[st_via[k]] <= st_row[k];
          row_partner[st_row[k]] <= st_via[k];
          if (k == '0) begin
            r <= r + NW'(1);
            state <= S_ROW;
          end else k <= k - 1'b1;
        end
        S_THETA: begin
          if (j == n) begin
            if (theta == SlackMax) begin
              r <= r + NW'(1);
              state <= S_ROW;
            end else begin
              i <= '0;
              state <= S_UPD;
            end
          end else begin
            if (!vcols[ji] && slack[ji] < theta) theta <= slack[ji];
            j <= j + NW'(1);
          end
        end
        S_UPD: begin
          if (vrows[i[IW-1:0]]) row_duals[i[IW-1:0]] <= row_duals[i[IW-1:0]] + DualW'(theta);
          else row_duals[i[IW-1:0]] <= row_duals[i[IW-1:0]] - DualW'(theta);
          if (vcols[i[IW-1:0]]) col_duals[i[IW-1:0]] <= col_duals[i[IW-1:0]] - DualW'(theta);
          else col_duals[i[IW-1:0]] <= col_duals[i[IW-1:0]] + DualW'(theta);
          if (i == n - NW'(1)) begin
            if (rnd == n) begin
              r <= r + NW'(1);
              state <= S_ROW;
            end else begin
              rnd <= rnd + NW'(1);
              state <= S_ROUND;
            end
          end else i <= i + NW'(1);
        end
        S_TOTAL: begin
          total <= total + row_duals[i[IW-1:0]] + col_duals[i[IW-1:0]];
          if (i == n - NW'(1)) begin
            i <= '0;
            state <= S_OUT;
          end else i <= i + NW'(1);
        end
        S_OUT: if (m_tready) begin
          if (i == n - NW'(1)) state <= S_LOAD;
          else i <= i + NW'(1);
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire
